// File: sv/iap_pkg.sv
// shared types and constants for the intercept aim point block
`timescale 1ns / 1ps
package iap_pkg;
	localparam int MaxPassesDef = 5;
	localparam int FracBitsDef  = 16;
	localparam logic [30:0] ShotSpeedRst = 31'd1310720;

	typedef enum logic [1:0] {
		REG_SHOT_SPEED = 2'd0,
		REG_SHOOTER_X  = 2'd1,
		REG_SHOOTER_Y  = 2'd2,
		REG_SHOOTER_Z  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] target_px;
		logic signed [31:0] target_py;
		logic signed [31:0] target_pz;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
		logic signed [31:0] target_vx;
		logic signed [31:0] target_vy;
		logic signed [31:0] target_vz;
		logic        [30:0] target_radius;
	} iap_in_t;

	typedef struct packed {
		logic signed [31:0] aim_x;
		logic signed [31:0] aim_y;
		logic signed [31:0] aim_z;
		logic        [3:0]  passes_used;
		logic               converged;
		logic               saturated;
	} iap_out_t;

	// saturate a 33 bit signed sum to 32 bits
	function automatic logic [32:0] sat33(input logic signed [32:0] v);
		logic [32:0] r;
		if (v > 33'sd2147483647) r = {1'b1, 32'h7fffffff};
		else if (v < -33'sd2147483648) r = {1'b1, 32'h80000000};
		else r = {1'b0, v[31:0]};
		return r;
	endfunction
endpackage

// File: sv/intercept_aim_point.sv
// intercept aim point top level: sequencer and shared arithmetic unit
`timescale 1ns / 1ps
// Computes a lead aim point for one request at a time. The target start point
// (position plus offset) is refined for up to MAX_PASSES passes. Each pass
// measures the shooter distance (three squares, one at a time, on a shared
// 32x32 multiplier, then a bit-serial square root, one result bit per cycle),
// divides it by shot_speed with a restoring divider (one quotient bit per
// cycle), moves the start point along the velocity (three multiplies), gets
// the reach (one multiply) and measures the new distance (three squares and a
// root).
// in_stall is high while a request is at work; the finished result sits in
// its own register, so the next request can be taken while it waits.
// Configuration must be written only while idle; the block does not enforce it.
module intercept_aim_point #(
	parameter int MAX_PASSES = iap_pkg::MaxPassesDef,
	parameter int FRAC_BITS  = iap_pkg::FracBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  iap_pkg::iap_in_t     in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output iap_pkg::iap_out_t    out_data
);
	import iap_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_START = 9'b000000010,
		ST_SQ    = 9'b000000100,
		ST_ROOT  = 9'b000001000,
		ST_DIV   = 9'b000010000,
		ST_MOVE  = 9'b000100000,
		ST_REACH = 9'b001000000,
		ST_CHECK = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	localparam int NumW = 32 + FRAC_BITS;
	localparam logic [5:0] NumLast = 6'(NumW - 1);
	// reset speed is 20.0 in the chosen fixed point format
	localparam logic [30:0] ShotSpeedReset = 31'(20 << FRAC_BITS);

	state_t state_q;

	// configuration
	logic [30:0] shot_speed_q;
	logic signed [31:0] shooter_q [3];

	// request working set
	logic signed [31:0] start_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] guess_q [3];
	logic [30:0] radius_q;
	logic sat_q;
	logic [3:0] passes_q;
	logic second_q;        // low: first distance of pass, high: new distance
	logic [1:0] k_q;       // component counter
	logic [5:0] bit_q;     // serial step counter
	logic [63:0] sum_q;    // sum of squares, also root remainder source
	logic [31:0] root_q;
	logic [33:0] rem_q;
	logic [31:0] dist_q;
	logic [NumW-1:0] num_q; // dividend shifted out msb first
	logic [31:0] quo_q;
	logic dv_ovf_q;        // a quotient bit above bit 31 was set
	logic [31:0] dvrem_q;
	logic [30:0] time_q;
	logic [31:0] reach_q;
	logic [31:0] miss_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	assign mul_p = mul_a * mul_b;

	logic signed [32:0] diff_raw;
	logic [32:0] diff_sat;
	logic [31:0] diff_mag;
	always_comb begin
		diff_raw = 33'(guess_q[k_q]) - 33'(shooter_q[k_q]);
		diff_sat = sat33(diff_raw);
		diff_mag = diff_sat[31] ? 32'(-diff_sat[31:0]) : diff_sat[31:0];
		mul_a = diff_mag;
		mul_b = diff_mag;
		if (state_q == ST_MOVE) begin
			mul_a = vel_q[k_q][31] ? 32'(-vel_q[k_q]) : vel_q[k_q];
			mul_b = {1'b0, time_q};
		end else if (state_q == ST_REACH) begin
			mul_a = {1'b0, shot_speed_q};
			mul_b = {1'b0, time_q};
		end
	end

	// root step: two bits of the radicand per cycle; also the divider trial and the saturated move sum
	logic [35:0] rtrial, rnext;
	logic [63:0] mv_shift;
	logic signed [33:0] mv_sum;
	logic [32:0] mv_sat;
	logic [32:0] dv_trial;
	always_comb begin
		rnext   = {rem_q, sum_q[63:62]};
		rtrial  = {2'b00, root_q, 2'b01};
		dv_trial = {dvrem_q, num_q[NumW-1]} - {2'b00, shot_speed_q};
		mv_shift = mul_p >> FRAC_BITS;
		mv_sum = vel_q[k_q][31]
			? 34'(start_q[k_q]) - $signed({2'b00, mv_shift[31:0]})
			: 34'(start_q[k_q]) + $signed({2'b00, mv_shift[31:0]});
		// a move of 2^32 or more always lands outside the 32 bit range
		if (|mv_shift[63:32]) mv_sat = {1'b1, vel_q[k_q][31] ? 32'h80000000 : 32'h7fffffff};
		else if (mv_sum > 34'sd2147483647) mv_sat = {1'b1, 32'h7fffffff};
		else if (mv_sum < -34'sd2147483648) mv_sat = {1'b1, 32'h80000000};
		else mv_sat = {1'b0, mv_sum[31:0]};
	end

	logic [32:0] st_sat;
	assign st_sat = sat33(33'(start_q[k_q]) + 33'(vel_q[k_q]));
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			shot_speed_q <= ShotSpeedReset;
			shooter_q[0] <= '0;
			shooter_q[1] <= '0;
			shooter_q[2] <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_SHOT_SPEED: shot_speed_q <= cfg_data[30:0];
					REG_SHOOTER_X:  shooter_q[0] <= cfg_data;
					REG_SHOOTER_Y:  shooter_q[1] <= cfg_data;
					REG_SHOOTER_Z:  shooter_q[2] <= cfg_data;
				endcase
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						start_q[0] <= in_data.target_px;
						start_q[1] <= in_data.target_py;
						start_q[2] <= in_data.target_pz;
						vel_q[0] <= in_data.offset_x;
						vel_q[1] <= in_data.offset_y;
						vel_q[2] <= in_data.offset_z;
						guess_q[0] <= in_data.target_vx;
						guess_q[1] <= in_data.target_vy;
						guess_q[2] <= in_data.target_vz;
						radius_q <= in_data.target_radius;
						sat_q <= 1'b0;
						passes_q <= '0;
						k_q <= '0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					// position plus offset, one component per cycle, loading the velocity alongside
					start_q[k_q] <= st_sat[31:0];
					guess_q[k_q] <= st_sat[31:0];
					vel_q[k_q] <= guess_q[k_q];
					if (st_sat[32]) sat_q <= 1'b1;
					if (k_q == 2'd2) begin
						k_q <= '0;
						sum_q <= '0;
						second_q <= 1'b0;
						state_q <= ST_SQ;
					end else k_q <= k_q + 2'd1;
				end
				ST_SQ: begin
					sum_q <= sum_q + mul_p;
					if (diff_sat[32]) sat_q <= 1'b1;
					if (k_q == 2'd2) begin
						k_q <= '0;
						root_q <= '0;
						rem_q <= '0;
						bit_q <= '0;
						state_q <= ST_ROOT;
					end else k_q <= k_q + 2'd1;
				end
				ST_ROOT: begin
					sum_q <= {sum_q[61:0], 2'b00};
					if (rnext >= rtrial) begin
						rem_q <= rnext[33:0] - rtrial[33:0];
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q <= rnext[33:0];
						root_q <= {root_q[30:0], 1'b0};
					end
					if (bit_q == 6'd31) begin
						if (!second_q) begin
							num_q <= {root_q[30:0], rnext >= rtrial, {FRAC_BITS{1'b0}}};
							dvrem_q <= '0;
							quo_q <= '0;
							dv_ovf_q <= 1'b0;
							bit_q <= '0;
							state_q <= ST_DIV;
						end else begin
							dist_q <= {root_q[30:0], rnext >= rtrial};
							state_q <= ST_CHECK;
						end
					end else bit_q <= bit_q + 6'd1;
				end
				ST_DIV: begin
					num_q <= {num_q[NumW-2:0], 1'b0};
					if (!dv_trial[32]) begin
						dvrem_q <= dv_trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						dvrem_q <= {dvrem_q[30:0], num_q[NumW-1]};
						quo_q <= {quo_q[30:0], 1'b0};
					end
					// a set bit leaving the top of the quotient means overflow
					if (quo_q[31]) dv_ovf_q <= 1'b1;
					if (bit_q == NumLast) begin
						bit_q <= '0;
						k_q <= '0;
						state_q <= ST_MOVE;
					end else bit_q <= bit_q + 6'd1;
				end
				ST_MOVE: begin
					guess_q[k_q] <= mv_sat[31:0];
					if (mv_sat[32]) sat_q <= 1'b1;
					if (k_q == 2'd2) begin
						k_q <= '0;
						state_q <= ST_REACH;
					end else k_q <= k_q + 2'd1;
				end
				ST_REACH: begin
					reach_q <= mv_shift[31:0];
					sum_q <= '0;
					second_q <= 1'b1;
					passes_q <= passes_q + 4'd1;
					state_q <= ST_SQ;
				end
				ST_CHECK: begin
					if (dist_q == '0) miss_q <= '0;
					else if (dist_q > reach_q) miss_q <= dist_q - reach_q;
					else miss_q <= reach_q - dist_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (miss_q > {1'b0, radius_q} && passes_q < 4'(MAX_PASSES)) begin
						sum_q <= '0;
						k_q <= '0;
						second_q <= 1'b0;
						state_q <= ST_SQ;
					end else if (!out_valid) begin
						out_data.aim_x <= guess_q[0];
						out_data.aim_y <= guess_q[1];
						out_data.aim_z <= guess_q[2];
						out_data.passes_used <= passes_q;
						out_data.converged <= (miss_q <= {1'b0, radius_q});
						out_data.saturated <= sat_q;
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// quotient clamp: time is the low 31 bits unless the quotient overflows
			if (state_q == ST_DIV && bit_q == NumLast) begin
				if (dv_ovf_q || quo_q[31] || quo_q[30]) begin
					time_q <= 31'h7fffffff;
					sat_q <= 1'b1;
				end else begin
					time_q <= {quo_q[29:0], !dv_trial[32]};
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("request taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> out_data.passes_used != 4'd0 &&
			out_data.passes_used <= 4'(MAX_PASSES))
		else $error("pass count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("result without finished request");
endmodule
